// ----- hw/rtl/edfs_pkg.sv -----
package edfs_pkg;

  localparam int MAX_TASKS = 8;
  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LABEL_W = 16;
  localparam int WORK_W = 16;
  localparam int TIME_W = 32;
  localparam int DL_W = TIME_W + 1;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_LOAD = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [1:0] KIND_MISS = 2'd0;
  localparam logic [1:0] KIND_RUN = 2'd1;
  localparam logic [1:0] KIND_IDLE = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic REG_ACTIVE_TASKS = 1'b0;
  localparam logic REG_RUN_LENGTH = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_BUSY,
    S_END
  } state_t;

  typedef struct packed {
    logic valid;
    logic found;
    logic [DL_W-1:0] deadline;
    logic [IDX_W-1:0] idx;
    logic [LABEL_W-1:0] label;
  } tok_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic dec;
    logic [IDX_W-1:0] dec_idx;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/edfs_cell.sv -----
module edfs_cell
  import edfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic [IDX_W-1:0] pos,
  input  logic active,
  input  logic [TIME_W-1:0] tick_time,
  input  cell_ctl_t ctl,
  input  logic [LABEL_W-1:0] load_label,
  input  logic [WORK_W-1:0] load_burst,
  input  logic [WORK_W-1:0] load_period,
  input  logic adv,
  input  tok_t tok_in,
  output tok_t tok_out,
  output logic miss,
  output logic [LABEL_W-1:0] miss_label
);

  logic [LABEL_W-1:0] label;
  logic [WORK_W-1:0] burst;
  logic [WORK_W-1:0] period;
  logic [WORK_W-1:0] rem;
  logic [DL_W-1:0] deadline;

  logic visit;
  logic release_now;
  logic [WORK_W-1:0] rem_post;
  logic [DL_W-1:0] dl_post;
  logic better;
  tok_t tok_next;

  assign visit = tok_in.valid && adv && active;
  assign release_now = (deadline == {1'b0, tick_time});
  assign rem_post = release_now ? burst : rem;
  assign dl_post = release_now ? (deadline + {{(DL_W-WORK_W){1'b0}}, period}) : deadline;
  assign better = (rem_post != '0) && (!tok_in.found || (dl_post < tok_in.deadline));

  assign miss = visit && release_now && (rem != '0);
  assign miss_label = label;

  always_comb begin
    tok_next = tok_in;
    if (active && better) begin
      tok_next.found = 1'b1;
      tok_next.deadline = dl_post;
      tok_next.idx = pos;
      tok_next.label = label;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (adv) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      label <= '0;
      burst <= '0;
      period <= '0;
      rem <= '0;
      deadline <= '0;
    end else if (ctl.load) begin
      label <= load_label;
      burst <= load_burst;
      period <= load_period;
      rem <= '0;
      deadline <= '0;
    end else if (ctl.restart) begin
      rem <= '0;
      deadline <= '0;
    end else if (ctl.dec && (ctl.dec_idx == pos)) begin
      rem <= rem - 1'b1;
    end else if (visit && release_now) begin
      rem <= rem_post;
      deadline <= dl_post;
    end
  end

endmodule

// ----- hw/rtl/edf_tick_scheduler_core.sv -----
// A tick's token is registered on acceptance and walks the slot cells one per cycle; output
// stalls hold it where it is, and the tick's final result is registered at the row's end.
// Misses are reported as the token passes and do not hold it up. No new item is taken until
// the tick is done; a tick at or past the run length gives a KIND_END result via S_END.
// Synchronous reset clears time, the state, all slot tables and the config registers to zero.
module edf_tick_scheduler_core
  import edfs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic cfg_index,
  input  logic [31:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] func,
  input  logic [2:0] slot,
  input  logic [15:0] task_label,
  input  logic [15:0] burst,
  input  logic [15:0] period,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] kind,
  output logic [15:0] result_label,
  output logic [31:0] time_now,
  output logic last
);

  state_t state;
  state_t state_next;

  logic [3:0] active_tasks;
  logic [TIME_W-1:0] run_length;
  logic [TIME_W-1:0] tick_time;

  logic in_accept;
  logic adv;
  logic tick_go;
  logic final_step;

  tok_t tok_chain [0:MAX_TASKS];
  logic [MAX_TASKS-1:0] cell_miss;
  logic [LABEL_W-1:0] cell_miss_label [0:MAX_TASKS-1];
  logic [MAX_TASKS-1:0] tok_busy;
  logic miss_any;
  logic [LABEL_W-1:0] miss_lab;
  cell_ctl_t ctl [0:MAX_TASKS-1];

  assign in_accept = in_valid && !in_stall;
  assign adv = !out_valid || !out_stall;
  assign tick_go = in_accept && (func == FUNC_TICK);
  assign final_step = tok_chain[MAX_TASKS].valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_tasks <= '0;
      run_length <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_TASKS: active_tasks <= cfg_data[3:0];
        REG_RUN_LENGTH:   run_length <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (tick_go) begin
          state_next = (tick_time >= run_length) ? S_END : S_BUSY;
        end
      end
      S_BUSY: begin
        if (final_step) begin
          state_next = S_IDLE;
        end
      end
      S_END: begin
        if (adv) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_chain[0] <= '0;
    end else if (tick_go && (tick_time < run_length)) begin
      tok_chain[0] <= '{valid: 1'b1, found: 1'b0, deadline: '0, idx: '0, label: '0};
    end else if (adv) begin
      tok_chain[0] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_time <= '0;
    end else if (in_accept && (func == FUNC_RESTART)) begin
      tick_time <= '0;
    end else if (final_step) begin
      tick_time <= tick_time + 1'b1;
    end
  end

  for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
    always_comb begin
      ctl[i].load = in_accept && (func == FUNC_LOAD) && ({29'b0, slot} == 32'(i));
      ctl[i].restart = in_accept && (func == FUNC_RESTART);
      ctl[i].dec = final_step && tok_chain[MAX_TASKS].found;
      ctl[i].dec_idx = tok_chain[MAX_TASKS].idx;
    end

    assign tok_busy[i] = tok_chain[i].valid;

    edfs_cell u_cell (
      .clk(clk),
      .rst(rst),
      .pos(IDX_W'(i)),
      .active({28'b0, active_tasks} > 32'(i)),
      .tick_time(tick_time),
      .ctl(ctl[i]),
      .load_label(task_label),
      .load_burst(burst),
      .load_period(period),
      .adv(adv),
      .tok_in(tok_chain[i]),
      .tok_out(tok_chain[i+1]),
      .miss(cell_miss[i]),
      .miss_label(cell_miss_label[i])
    );
  end

  always_comb begin
    miss_lab = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      miss_lab = miss_lab | (cell_miss[i] ? cell_miss_label[i] : '0);
    end
  end
  assign miss_any = |cell_miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= miss_any || final_step || (state == S_END);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (miss_any) begin
        kind <= KIND_MISS;
        result_label <= miss_lab;
        time_now <= tick_time;
        last <= 1'b0;
      end else if (final_step) begin
        kind <= tok_chain[MAX_TASKS].found ? KIND_RUN : KIND_IDLE;
        result_label <= tok_chain[MAX_TASKS].found ? tok_chain[MAX_TASKS].label : '0;
        time_now <= tick_time;
        last <= 1'b1;
      end else if (state == S_END) begin
        kind <= KIND_END;
        result_label <= '0;
        time_now <= tick_time;
        last <= 1'b1;
      end
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0({tok_chain[MAX_TASKS].valid, tok_busy}))
    else $error("more than one scheduling token in the cell row");

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (!tok_chain[MAX_TASKS].valid && (tok_busy == '0)))
    else $error("token in flight while no tick is being processed");

  a_miss_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_MISS)) |-> !last)
    else $error("deadline miss marked as final result of a tick");

  a_time_steady: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_BUSY && state == S_BUSY) |-> $stable(tick_time))
    else $error("tick time changed in the middle of a tick");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
  import edfs_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int ITEMS_WANTED = 420;
  localparam int STUCK_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0] kind;
    logic [15:0] label;
    logic [31:0] stamp;
    logic fin;
  } sched_event_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t row;
    logic [1:0] f;
    logic [2:0] s;
    logic [15:0] lb;
    logic [15:0] bu;
    logic [15:0] pe;
    logic [3:0] act;
    logic [31:0] len;
    logic typed;
    logic [1:0] e_kind;
    logic [31:0] e_time;
  } dir_row_t;

  localparam int N_DIRECTED = 25;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_ACTIVE_TASKS;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] func = FUNC_TICK;
  logic [2:0] slot = '0;
  logic [15:0] task_label = '0;
  logic [15:0] burst = '0;
  logic [15:0] period = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] kind;
  logic [15:0] result_label;
  logic [31:0] time_now;
  logic last;

  // Shadow of the scheduler state, advanced as each item is accepted.
  logic [3:0] cfg_active;
  logic [31:0] cfg_run_len;
  logic [15:0] slot_label [MAX_TASKS];
  logic [15:0] slot_burst [MAX_TASKS];
  logic [15:0] slot_period [MAX_TASKS];
  logic [15:0] work_left [MAX_TASKS];
  logic [32:0] release_at [MAX_TASKS];
  logic [31:0] sched_time;

  sched_event_t due_events[$];
  int fail_count = 0;
  int items_sent = 0;
  int stuck_cycles = 0;
  bit no_idle = 1'b0;
  bit hold_wanted = 1'b0;
  bit hold_done = 1'b0;

  dir_row_t directed_rows [N_DIRECTED] = '{
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b1, KIND_END, 32'd0},
    '{ROW_CFG, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd1000, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b1, KIND_IDLE, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 32'd0, 1'b1, KIND_IDLE, 32'd1},
    '{ROW_ITEM, FUNC_LOAD, 3'd0, 16'hFFFF, 16'd2, 16'd3, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_LOAD, 3'd1, 16'h0000, 16'hFFFF, 16'hFFFF, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_LOAD, 3'd2, 16'h00A5, 16'd0, 16'd0, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_LOAD, 3'd3, 16'h5A5A, 16'd3, 16'd2, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_LOAD, 3'd7, 16'h1234, 16'd1, 16'd1, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_UNUSED, 3'd5, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_RESTART, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_CFG, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd4, 32'd6, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd2, 16'h5555, 16'hAAAA, 16'h5555, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd5, 16'hAAAA, 16'h5555, 16'hAAAA, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b1, KIND_END, 32'd6},
    '{ROW_CFG, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd15, 32'hFFFF_FFFF, 1'b0, KIND_END,
      32'd0},
    '{ROW_ITEM, FUNC_RESTART, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0},
    '{ROW_ITEM, FUNC_TICK, 3'd0, 16'h0000, 16'h0000, 16'h0000, 4'd0, 32'd0, 1'b0, KIND_END, 32'd0}
  };

  edf_tick_scheduler_core u_top (.*);

  always #6 clk = ~clk;

  function automatic void note_event(input logic [1:0] k, input logic [15:0] lb,
                                     input logic [31:0] t, input logic fin);
    sched_event_t ev;
    ev.kind = k;
    ev.label = lb;
    ev.stamp = t;
    ev.fin = fin;
    due_events.push_back(ev);
  endfunction

  // Advances the shadow scheduler by one item and queues the results it causes.
  function automatic int edf_apply(input logic [1:0] f, input logic [2:0] s,
                                   input logic [15:0] lb, input logic [15:0] bu,
                                   input logic [15:0] pe);
    int n;
    int count;
    int pick;
    n = 0;
    pick = -1;
    count = (int'(cfg_active) > MAX_TASKS) ? MAX_TASKS : int'(cfg_active);
    if (f == FUNC_LOAD) begin
      if (int'(s) < MAX_TASKS) begin
        slot_label[s] = lb;
        slot_burst[s] = bu;
        slot_period[s] = pe;
        work_left[s] = '0;
        release_at[s] = '0;
      end
    end else if (f == FUNC_RESTART) begin
      sched_time = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        work_left[i] = '0;
        release_at[i] = '0;
      end
    end else if (f == FUNC_TICK) begin
      if (sched_time >= cfg_run_len) begin
        note_event(KIND_END, 16'd0, sched_time, 1'b1);
        n = 1;
      end else begin
        for (int i = 0; i < count; i++) begin
          if (release_at[i] == {1'b0, sched_time}) begin
            if (work_left[i] != 16'd0) begin
              note_event(KIND_MISS, slot_label[i], sched_time, 1'b0);
              n++;
            end
            work_left[i] = slot_burst[i];
            release_at[i] = release_at[i] + 33'(slot_period[i]);
          end
        end
        for (int i = 0; i < count; i++) begin
          if (work_left[i] != 16'd0 && (pick < 0 || release_at[i] < release_at[pick])) begin
            pick = i;
          end
        end
        if (pick < 0) begin
          note_event(KIND_IDLE, 16'd0, sched_time, 1'b1);
        end else begin
          note_event(KIND_RUN, slot_label[pick], sched_time, 1'b1);
          work_left[pick] = work_left[pick] - 16'd1;
        end
        n++;
        sched_time = sched_time + 32'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [15:0] rand_burst();
    return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
  endfunction

  function automatic logic [15:0] rand_period();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      return 16'd0;
    end else if (pick == 1) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(1, 10));
  endfunction

  task automatic send_item(input logic [1:0] f, input logic [2:0] s, input logic [15:0] lb,
                           input logic [15:0] bu, input logic [15:0] pe, output int n_out);
    int gap;
    gap = 0;
    no_idle = (items_sent >= ITEMS_WANTED - 50);
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 16);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    slot <= s;
    task_label <= lb;
    burst <= bu;
    period <= pe;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_out = edf_apply(f, s, lb, bu, pe);
    if (f != FUNC_UNUSED) begin
      items_sent++;
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_regs(input logic [3:0] act, input logic [31:0] len);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_ACTIVE_TASKS;
    cfg_data <= {28'd0, act};
    @(posedge clk);
    cfg_index <= REG_RUN_LENGTH;
    cfg_data <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_active = act;
    cfg_run_len = len;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  initial begin : stimulus
    int n;
    int pick;
    int ticks;
    logic [3:0] act;
    logic [31:0] len;
    sched_event_t typed_event;
    cfg_active = '0;
    cfg_run_len = '0;
    sched_time = '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      slot_label[i] = '0;
      slot_burst[i] = '0;
      slot_period[i] = '0;
      work_left[i] = '0;
      release_at[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].row == ROW_CFG) begin
        write_regs(directed_rows[r].act, directed_rows[r].len);
      end else begin
        send_item(directed_rows[r].f, directed_rows[r].s, directed_rows[r].lb,
                  directed_rows[r].bu, directed_rows[r].pe, n);
        if (directed_rows[r].typed) begin
          repeat (n) void'(due_events.pop_back());
          typed_event.kind = directed_rows[r].e_kind;
          typed_event.label = 16'd0;
          typed_event.stamp = directed_rows[r].e_time;
          typed_event.fin = 1'b1;
          due_events.push_back(typed_event);
        end
      end
    end

    while (items_sent < ITEMS_WANTED) begin
      pick = $urandom_range(0, 11);
      if (pick == 0) begin
        act = 4'($urandom_range(9, 15));
      end else if (pick == 1) begin
        act = 4'd0;
      end else begin
        act = 4'($urandom_range(1, 8));
      end
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        len = 32'd0;
      end else if (pick == 1) begin
        len = 32'hFFFF_FFFF;
      end else if (pick == 2) begin
        len = $urandom;
      end else begin
        len = $urandom_range(10, 60);
      end
      write_regs(act, len);

      for (int i = 0; i < MAX_TASKS; i++) begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(FUNC_LOAD, 3'(i), 16'($urandom), rand_burst(), rand_period(), n);
        end
      end
      if ($urandom_range(0, 5) != 0) begin
        send_item(FUNC_RESTART, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), n);
      end

      ticks = $urandom_range(15, 50);
      repeat (ticks) begin
        pick = $urandom_range(0, 24);
        if (pick == 0) begin
          send_item(FUNC_LOAD, 3'($urandom), 16'($urandom), rand_burst(), rand_period(), n);
        end else if (pick == 1) begin
          send_item(FUNC_RESTART, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                    n);
        end else if (pick == 2) begin
          send_item(FUNC_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), n);
        end else begin
          if (!hold_done && items_sent >= 90) begin
            hold_done = 1'b1;
            hold_wanted = 1'b1;
          end
          send_item(FUNC_TICK, 3'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), n);
        end
      end
    end

    in_valid <= 1'b0;
    while (due_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_side
    sched_event_t want;
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (due_events.size() == 0) begin
          $error("unexpected result item: kind %0d, label %0h, time %0d", kind, result_label,
                 time_now);
          fail_count++;
        end else begin
          want = due_events.pop_front();
          check_field("kind", 32'(want.kind), 32'(kind));
          check_field("result_label", 32'(want.label), 32'(result_label));
          check_field("time_now", want.stamp, time_now);
          check_field("last", 32'(want.fin), 32'(last));
        end
      end
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

// ----- files.f -----
hw/rtl/edfs_pkg.sv
hw/rtl/edfs_cell.sv
hw/rtl/edf_tick_scheduler_core.sv
bench/tb_top.sv
